// ===== design/jsu_pkg.sv =====
// Shared types and constants of the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

    // Depth of the command queue between the front and the back part.
    localparam int unsigned C_FIFO_DEPTH = 4;

    // Bytes of the string syntax.
    localparam logic [7:0] C_QUOTE     = 8'h22;
    localparam logic [7:0] C_BACKSLASH = 8'h5c;
    localparam logic [7:0] C_SLASH     = 8'h2f;
    localparam logic [7:0] C_LETTER_B  = 8'h62;
    localparam logic [7:0] C_LETTER_F  = 8'h66;
    localparam logic [7:0] C_LETTER_N  = 8'h6e;
    localparam logic [7:0] C_LETTER_R  = 8'h72;
    localparam logic [7:0] C_LETTER_T  = 8'h74;
    localparam logic [7:0] C_LETTER_U  = 8'h75;

    // Control characters that the short escapes stand for.
    localparam logic [7:0] C_BS  = 8'h08;
    localparam logic [7:0] C_FF  = 8'h0c;
    localparam logic [7:0] C_LF  = 8'h0a;
    localparam logic [7:0] C_CR  = 8'h0d;
    localparam logic [7:0] C_TAB = 8'h09;

    // UTF-8 marker bits.
    localparam logic [7:0] C_UTF8_LEAD2 = 8'hc0;
    localparam logic [7:0] C_UTF8_LEAD3 = 8'he0;
    localparam logic [7:0] C_UTF8_CONT  = 8'h80;

    typedef enum logic [2:0] {
        MODE_TEXT = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_HEX1 = 3'd2,
        MODE_HEX2 = 3'd3,
        MODE_HEX3 = 3'd4,
        MODE_HEX4 = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // One queued command: up to three result bytes, sent from byte0 up.
    typedef struct packed {
        logic [7:0] byte2;
        logic [7:0] byte1;
        logic [7:0] byte0;
        logic [1:0] cnt;    // number of results, 1 to 3
        t_kind      kind;
    } t_cmd;

endpackage

// ===== design/jsu_front.sv =====
// Front part: escape state machine that turns input items into commands.
`timescale 1ns / 1ps

module jsu_front
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eoi,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_mode       r_mode,  n_mode;
    logic [11:0] r_accum, n_accum;

    logic        w_accept;
    logic        w_has_result;
    logic        w_hex_ok;
    logic [3:0]  w_hex_v;
    logic [15:0] w_cp;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && w_has_result;
    assign w_cp     = {r_accum, w_hex_v};

    // Hex digit decode: 0-9, a-f, A-F.
    always_comb begin
        w_hex_ok = 1'b1;
        w_hex_v  = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            w_hex_v = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            w_hex_v = 4'(i_byte - 8'h61 + 8'd10);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            w_hex_v = 4'(i_byte - 8'h41 + 8'd10);
        end else begin
            w_hex_ok = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        n_mode  = r_mode;
        n_accum = r_accum;
        unique case (r_mode)
            MODE_ESC: begin
                n_mode  = MODE_TEXT;
                n_accum = '0;
                if (!i_eoi && i_byte == C_LETTER_U) begin
                    n_mode = MODE_HEX1;
                end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                if (i_eoi || !w_hex_ok) begin
                    n_mode  = MODE_TEXT;
                    n_accum = '0;
                end else begin
                    n_mode  = t_mode'(r_mode + 3'd1);
                    n_accum = {r_accum[7:0], w_hex_v};
                end
            end
            MODE_HEX4: begin
                n_mode  = MODE_TEXT;
                n_accum = '0;
            end
            default: begin
                // Normal text, also any unused code.
                n_mode = MODE_TEXT;
                if (i_eoi || i_byte == C_QUOTE) begin
                    n_accum = '0;
                end else if (i_byte == C_BACKSLASH) begin
                    n_mode = MODE_ESC;
                end
            end
        endcase
    end

    // Outputs: the command that this item causes, if any.
    always_comb begin
        o_cmd        = '0;
        o_cmd.kind   = KIND_DATA;
        o_cmd.cnt    = 2'd1;
        w_has_result = 1'b1;
        unique case (r_mode)
            MODE_ESC: begin
                if (i_eoi) begin
                    o_cmd.kind = KIND_ERROR;
                end else begin
                    unique case (i_byte)
                        C_QUOTE:     o_cmd.byte0 = C_QUOTE;
                        C_BACKSLASH: o_cmd.byte0 = C_BACKSLASH;
                        C_SLASH:     o_cmd.byte0 = C_SLASH;
                        C_LETTER_B:  o_cmd.byte0 = C_BS;
                        C_LETTER_F:  o_cmd.byte0 = C_FF;
                        C_LETTER_N:  o_cmd.byte0 = C_LF;
                        C_LETTER_R:  o_cmd.byte0 = C_CR;
                        C_LETTER_T:  o_cmd.byte0 = C_TAB;
                        C_LETTER_U:  w_has_result = 1'b0;
                        default:     o_cmd.kind = KIND_ERROR;
                    endcase
                end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                if (i_eoi || !w_hex_ok) begin
                    o_cmd.kind = KIND_ERROR;
                end else begin
                    w_has_result = 1'b0;
                end
            end
            MODE_HEX4: begin
                if (i_eoi || !w_hex_ok) begin
                    o_cmd.kind = KIND_ERROR;
                end else if (w_cp[15:7] == '0) begin
                    o_cmd.byte0 = w_cp[7:0];
                end else if (w_cp[15:11] == '0) begin
                    o_cmd.cnt   = 2'd2;
                    o_cmd.byte0 = C_UTF8_LEAD2 | {3'b000, w_cp[10:6]};
                    o_cmd.byte1 = C_UTF8_CONT  | {2'b00, w_cp[5:0]};
                end else begin
                    o_cmd.cnt   = 2'd3;
                    o_cmd.byte0 = C_UTF8_LEAD3 | {4'b0000, w_cp[15:12]};
                    o_cmd.byte1 = C_UTF8_CONT  | {2'b00, w_cp[11:6]};
                    o_cmd.byte2 = C_UTF8_CONT  | {2'b00, w_cp[5:0]};
                end
            end
            default: begin
                if (i_eoi || i_byte == C_QUOTE) begin
                    o_cmd.kind = KIND_DONE;
                end else if (i_byte == C_BACKSLASH) begin
                    w_has_result = 1'b0;
                end else begin
                    o_cmd.byte0 = i_byte;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_TEXT;
            r_accum <= '0;
        end else if (w_accept) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
        end
    end

    // A backslash taken in text mode, not at end of input, opens an escape.
    a_esc_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode == MODE_TEXT && !i_eoi && i_byte == C_BACKSLASH)
        |=> (r_mode == MODE_ESC))
        else $error("backslash did not open an escape");

    // The last hex digit always closes the escape.
    a_hex_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode == MODE_HEX4) |=> (r_mode == MODE_TEXT))
        else $error("escape left open after last hex digit");

    // Only multi-byte UTF-8 comes with more than one result.
    a_cnt_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.cnt != 2'd1) |-> (o_cmd.kind == KIND_DATA && r_mode == MODE_HEX4))
        else $error("multi-result command outside a unicode escape");

endmodule

// ===== design/jsu_fifo.sv =====
// Command queue between the front and the back part.
`timescale 1ns / 1ps

module jsu_fifo
    import jsu_pkg::*;
#(
    parameter int unsigned DEPTH = C_FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into a full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== design/jsu_back.sv =====
// Back part: splits commands into result items behind an output register.
`timescale 1ns / 1ps

module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output t_kind      o_kind,
    output logic       o_last
);

    logic       r_busy;
    t_cmd       r_cmd;
    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    t_kind      r_kind;
    logic       r_last;

    logic       w_load;
    logic       w_at_end;
    logic       w_done;
    logic [7:0] w_byte;

    assign w_load   = r_busy && (!r_valid || i_ready);
    assign w_at_end = (r_idx == r_cmd.cnt - 2'd1);
    assign w_done   = w_load && w_at_end;
    assign o_q_pop  = i_q_valid && (!r_busy || w_done);

    always_comb begin
        unique case (r_idx)
            2'd1:    w_byte = r_cmd.byte1;
            2'd2:    w_byte = r_cmd.byte2;
            default: w_byte = r_cmd.byte0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (w_load) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (w_load) begin
            r_byte <= w_byte;
            r_kind <= r_cmd.kind;
            r_last <= w_at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_kind  = r_kind;
    assign o_last  = r_last;

    // Done and error are single results, so they always close the item.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind != KIND_DATA) |-> r_last)
        else $error("status result not marked last");

    // The index never runs past the command's byte count.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_cmd.cnt))
        else $error("result index past command length");

endmodule

// ===== design/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
// An item's first result passes the command queue, command register and output register.
// Throughput: one item per cycle in and one result per cycle out, each unless stalled.
// A \uXXXX escape takes 6 items and gives at most 3 results, so the queue only fills
// while the consumer stalls; the input then stalls once the queue is full.
// Reset (i_rst_n low at a clock edge) returns to text mode and empties queue and output.
`timescale 1ns / 1ps

module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = C_FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tuser,   // [0] end_of_input
    // Result stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_tuser,   // [1:0] kind
    output logic       o_m_tlast    // last result of the input item
);

    // Commands from the front part, one per item that has any result.
    logic  w_push;
    t_cmd  w_push_cmd;
    logic  w_q_full;

    // Queue head toward the back part.
    logic  w_q_valid;
    t_cmd  w_q_cmd;
    logic  w_q_pop;

    t_kind w_kind;

    // Classify each byte and track the escape state; stall only on a full queue.
    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_byte   (i_s_tdata),
        .i_eoi    (i_s_tuser),
        .i_q_full (w_q_full),
        .o_ready  (o_s_tready),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    // Hold commands while the consumer stalls or a multi-byte result drains.
    jsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // Emit the bytes of each command one per cycle through the output register, unless stalled.
    jsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_byte    (o_m_tdata),
        .o_kind    (w_kind),
        .o_last    (o_m_tlast)
    );

    assign o_m_tuser = w_kind;

    // A held result keeps its payload until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("result changed while stalled");

    // Nothing goes out of an empty pipeline.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_q_pop, 2) || $past(u_back.r_busy))
        else $error("result appeared with no command behind it");

endmodule
